[hdl/mp2d_pkg.sv]
// Shared types, constants and helpers for the streaming 2-D max pooling block.
`timescale 1ns / 1ps
package mp2d_pkg;

  localparam int DATA_W       = 16;
  localparam int MAX_WIDTH    = 256;
  localparam int MAX_CHANNELS = 1024;
  localparam int MAX_POOL     = 4;
  localparam int MAX_PAD      = 3;
  localparam int IDX_W        = 9;
  localparam int CH_W         = 10;
  localparam int SLOT_W       = 2;
  localparam int COL_AW       = 9;
  localparam int ADDR_W       = SLOT_W + COL_AW;
  localparam int STORE_DEPTH  = 2 ** ADDR_W;
  localparam int CFG_DATA_W   = 11;
  localparam int CFG_IDX_W    = 3;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = 2;

  localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_WIDTH      = 3'd0,
    REG_IN_HEIGHT     = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_POOL_SIZE     = 3'd3,
    REG_POOL_STRIDE   = 3'd4,
    REG_PAD_AMOUNT    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EXEC
  } back_state_t;

  // Effective (clamped) layer configuration.
  typedef struct packed {
    logic [IDX_W-1:0] w;
    logic [IDX_W-1:0] h;
    logic [10:0]      nc;
    logic [2:0]       k;
    logic [2:0]       s;
    logic [1:0]       p;
  } pool_cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] pooled_value;
    logic [CH_W-1:0]          out_channel;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     run_last;
    logic                     layer_done;
  } out_item_t;

  // What one axis tracker reports about the current position.
  typedef struct packed {
    logic [IDX_W-1:0] pos;
    logic             at_last;
    logic             cov_ok;
    logic [IDX_W-1:0] cov_lo;
    logic [IDX_W-1:0] cov_hi;
    logic             emit_ok;
    logic [IDX_W-1:0] emit_lo;
    logic [IDX_W-1:0] emit_hi;
  } axis_view_t;

  // Work for the back end: one sample and the window box it touches.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic [CH_W-1:0]          channel;
    logic [IDX_W-1:0]         ur_lo;
    logic [IDX_W-1:0]         ur_hi;
    logic [IDX_W-1:0]         uc_lo;
    logic [IDX_W-1:0]         uc_hi;
    logic                     cov_ok;
    logic [IDX_W-1:0]         cr_lo;
    logic [IDX_W-1:0]         cr_hi;
    logic [IDX_W-1:0]         cc_lo;
    logic [IDX_W-1:0]         cc_hi;
    logic                     emit_ok;
    logic [IDX_W-1:0]         er_lo;
    logic [IDX_W-1:0]         er_hi;
    logic [IDX_W-1:0]         ec_lo;
    logic [IDX_W-1:0]         ec_hi;
    logic                     layer_end;
  } job_t;

  // Quotient (upper two bits) and remainder (lower three) of a pad by a stride.
  function automatic logic [4:0] div_small(input logic [1:0] num, input logic [2:0] den);
    logic [2:0] rem;
    logic [1:0] quo;
    rem = {1'b0, num};
    quo = 2'd0;
    for (int n = 0; n < 3; n++) begin
      if (rem >= den) begin
        rem = rem - den;
        quo = quo + 2'd1;
      end
    end
    return {quo, rem};
  endfunction

endpackage

[hdl/mp2d_stream_if.sv]
// Valid/ready stream channel carrying one payload item per transfer.
`timescale 1ns / 1ps
interface mp2d_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/mp2d_axis_track.sv]
// Position tracker for one axis: window cover and emission ranges, output size.
`timescale 1ns / 1ps
module mp2d_axis_track (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       init,
  input  logic                       adv,
  input  logic                       wrap,
  input  logic [mp2d_pkg::IDX_W-1:0] dim,
  input  logic [2:0]                 k,
  input  logic [2:0]                 s,
  input  logic [1:0]                 p,
  output logic                       busy,
  output mp2d_pkg::axis_view_t       view
);
  import mp2d_pkg::*;

  // u = pos + p and e = pos + p + 1 - k are kept as quotient/remainder by s.
  logic [IDX_W-1:0] pos_r, pos_nxt, qu_r, qu_nxt, qe_r, qe_nxt, nout_r, nout_nxt;
  logic [2:0]       ru_r, ru_nxt, re_r, re_nxt;
  logic [1:0]       pre_r, pre_nxt;
  logic [IDX_W:0]   acc_r, acc_nxt;
  logic             busy_r, busy_nxt;
  logic [IDX_W:0]   total, acc_step, clo_w;
  logic [4:0]       qr0;
  logic [1:0]       pre0;
  logic [IDX_W-1:0] clo, chi, last_out;

  always_comb begin
    qr0      = div_small(p, s);
    pre0     = 2'(k - 3'd1 - {1'b0, p});
    total    = {1'b0, dim} + (IDX_W+1)'({p, 1'b0});
    acc_step = acc_r + (IDX_W+1)'(s);

    pos_nxt  = pos_r;
    qu_nxt   = qu_r;
    ru_nxt   = ru_r;
    qe_nxt   = qe_r;
    re_nxt   = re_r;
    pre_nxt  = pre_r;
    acc_nxt  = acc_r;
    nout_nxt = nout_r;
    busy_nxt = busy_r;

    if (init || wrap) begin
      pos_nxt = '0;
      qu_nxt  = IDX_W'(qr0[4:3]);
      ru_nxt  = qr0[2:0];
      pre_nxt = pre0;
      qe_nxt  = '0;
      re_nxt  = '0;
    end else if (adv) begin
      pos_nxt = pos_r + 1'b1;
      if (ru_r + 3'd1 == s) begin
        ru_nxt = '0;
        qu_nxt = qu_r + 1'b1;
      end else begin
        ru_nxt = ru_r + 3'd1;
      end
      if (pre_r != 2'd0) begin
        pre_nxt = pre_r - 2'd1;
      end else if (re_r + 3'd1 == s) begin
        re_nxt = '0;
        qe_nxt = qe_r + 1'b1;
      end else begin
        re_nxt = re_r + 3'd1;
      end
    end

    // Output size by repeated addition of the stride after each restart.
    if (init) begin
      busy_nxt = 1'b1;
      acc_nxt  = '0;
      nout_nxt = '0;
    end else if (busy_r) begin
      if (acc_step <= total) begin
        acc_nxt  = acc_step;
        nout_nxt = nout_r + 1'b1;
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      qu_r   <= '0;
      ru_r   <= '0;
      qe_r   <= '0;
      re_r   <= '0;
      pre_r  <= '0;
      acc_r  <= '0;
      nout_r <= '0;
      busy_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      qu_r   <= qu_nxt;
      ru_r   <= ru_nxt;
      qe_r   <= qe_nxt;
      re_r   <= re_nxt;
      pre_r  <= pre_nxt;
      acc_r  <= acc_nxt;
      nout_r <= nout_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_comb begin
    clo_w    = {1'b0, qe_r} + (IDX_W+1)'(re_r != 3'd0);
    clo      = (pre_r != 2'd0) ? '0 : clo_w[IDX_W-1:0];
    last_out = nout_r - 1'b1;
    chi      = (qu_r < nout_r) ? qu_r : last_out;

    view.pos     = pos_r;
    view.at_last = (pos_r + 1'b1 == dim);
    view.cov_ok  = (nout_r != '0) && (clo <= chi);
    view.cov_lo  = clo;
    view.cov_hi  = chi;
    if (view.at_last) begin
      // The edge sample closes every remaining window, including those past the edge.
      view.emit_ok = (clo < nout_r);
      view.emit_lo = clo;
      view.emit_hi = last_out;
    end else begin
      view.emit_ok = (pre_r == 2'd0) && (re_r == 3'd0) && (qe_r < nout_r);
      view.emit_lo = qe_r;
      view.emit_hi = qe_r;
    end
  end

  assign busy = busy_r;

endmodule

[hdl/mp2d_front.sv]
// Front end: accepts samples, tracks position and queues the window work per sample.
`timescale 1ns / 1ps
module mp2d_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  mp2d_pkg::pool_cfg_t       cfg,
  mp2d_stream_if.sink               in_strm,
  input  logic                      fifo_full,
  output logic                      push,
  output mp2d_pkg::job_t            job
);
  import mp2d_pkg::*;

  axis_view_t      cview, rview;
  logic            cbusy, rbusy, accept, col_wrap, row_adv, row_wrap, ch_last;
  logic            cov_both, emit_both;
  logic [CH_W-1:0] ch_r, ch_nxt;

  assign in_strm.ready = !start && !cbusy && !rbusy && !fifo_full;
  assign accept        = in_strm.valid && in_strm.ready;
  assign col_wrap      = accept && cview.at_last;
  assign row_adv       = col_wrap;
  assign row_wrap      = row_adv && rview.at_last;
  assign ch_last       = ({1'b0, ch_r} + 11'd1 == cfg.nc);

  mp2d_axis_track u_col (
    .clk   (clk),
    .rst_n (rst_n),
    .init  (start),
    .adv   (accept),
    .wrap  (col_wrap),
    .dim   (cfg.w),
    .k     (cfg.k),
    .s     (cfg.s),
    .p     (cfg.p),
    .busy  (cbusy),
    .view  (cview)
  );

  mp2d_axis_track u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .init  (start),
    .adv   (row_adv),
    .wrap  (row_wrap),
    .dim   (cfg.h),
    .k     (cfg.k),
    .s     (cfg.s),
    .p     (cfg.p),
    .busy  (rbusy),
    .view  (rview)
  );

  always_comb begin
    ch_nxt = ch_r;
    if (start) begin
      ch_nxt = '0;
    end else if (row_wrap) begin
      ch_nxt = ch_last ? '0 : ch_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0;
    end else begin
      ch_r <= ch_nxt;
    end
  end

  always_comb begin
    cov_both  = rview.cov_ok && cview.cov_ok;
    emit_both = rview.emit_ok && cview.emit_ok;

    job.value     = in_strm.data.sample_value;
    job.row       = rview.pos;
    job.col       = cview.pos;
    job.channel   = ch_r;
    job.cov_ok    = cov_both;
    job.cr_lo     = rview.cov_lo;
    job.cr_hi     = rview.cov_hi;
    job.cc_lo     = cview.cov_lo;
    job.cc_hi     = cview.cov_hi;
    job.emit_ok   = emit_both;
    job.er_lo     = rview.emit_lo;
    job.er_hi     = rview.emit_hi;
    job.ec_lo     = cview.emit_lo;
    job.ec_hi     = cview.emit_hi;
    job.layer_end = rview.at_last && cview.at_last && ch_last;

    // The scan box spans the covered windows and the emitted ones; emitted
    // windows never start before the covered ones.
    if (cov_both) begin
      job.ur_lo = rview.cov_lo;
      job.uc_lo = cview.cov_lo;
      job.ur_hi = (emit_both && rview.emit_hi > rview.cov_hi) ? rview.emit_hi : rview.cov_hi;
      job.uc_hi = (emit_both && cview.emit_hi > cview.cov_hi) ? cview.emit_hi : cview.cov_hi;
    end else begin
      job.ur_lo = rview.emit_lo;
      job.uc_lo = cview.emit_lo;
      job.ur_hi = rview.emit_hi;
      job.uc_hi = cview.emit_hi;
    end

    push = accept && (cov_both || emit_both);
  end

endmodule

[hdl/mp2d_job_fifo.sv]
// Small queue of window jobs between the front end and the back end.
`timescale 1ns / 1ps
module mp2d_job_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mp2d_pkg::job_t din,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output mp2d_pkg::job_t dout
);
  import mp2d_pkg::*;

  job_t               entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r, count_nxt;

  assign full      = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign dout      = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= din;
    end
  end

endmodule

[hdl/mp2d_back.sv]
// Back end: walks each job's window box, keeps running maxima and emits results.
`timescale 1ns / 1ps
module mp2d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mp2d_pkg::pool_cfg_t cfg,
  input  logic                job_valid,
  input  mp2d_pkg::job_t      job,
  output logic                pop,
  mp2d_stream_if.source       out_strm
);
  import mp2d_pkg::*;

  back_state_t              state_r, state_nxt;
  logic [IDX_W-1:0]         i_r, j_r;
  logic signed [DATA_W-1:0] store [STORE_DEPTH];
  logic signed [DATA_W-1:0] rd_r, newv, result, val;
  logic [ADDR_W-1:0]        addr;
  logic [IDX_W+2:0]         is, js;
  logic                     covered, emitted, fresh, outside, last_cell, stall, advance;
  logic                     mem_we, load, out_valid_r, run_last;
  out_item_t                out_r;

  assign addr = {i_r[SLOT_W-1:0], j_r[COL_AW-1:0]};
  assign val  = $signed(job.value);

  always_comb begin
    is = (IDX_W+3)'(i_r) * (IDX_W+3)'(cfg.s);
    js = (IDX_W+3)'(j_r) * (IDX_W+3)'(cfg.s);

    covered = job.cov_ok && (i_r >= job.cr_lo) && (i_r <= job.cr_hi)
                         && (j_r >= job.cc_lo) && (j_r <= job.cc_hi);
    emitted = job.emit_ok && (i_r >= job.er_lo) && (i_r <= job.er_hi)
                          && (j_r >= job.ec_lo) && (j_r <= job.ec_hi);

    // A window starts afresh at its first in-range sample, so stale entries never count.
    fresh = ((job.row == '0) || ((IDX_W+3)'(job.row) + (IDX_W+3)'(cfg.p) == is)) &&
            ((job.col == '0) || ((IDX_W+3)'(job.col) + (IDX_W+3)'(cfg.p) == js));
    outside = (is >= (IDX_W+3)'(cfg.h) + (IDX_W+3)'(cfg.p)) ||
              (js >= (IDX_W+3)'(cfg.w) + (IDX_W+3)'(cfg.p));

    newv     = (fresh || val > rd_r) ? val : rd_r;
    result   = (outside || !covered) ? MOST_NEG : newv;
    run_last = (i_r == job.er_hi) && (j_r == job.ec_hi);

    last_cell = (i_r == job.ur_hi) && (j_r == job.uc_hi);
    stall     = emitted && out_valid_r && !out_strm.ready;
    advance   = (state_r == BK_EXEC) && !stall;
    mem_we    = advance && covered;
    load      = advance && emitted;
    pop       = advance && last_cell;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (job_valid) begin
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        state_nxt = BK_EXEC;
      end
      BK_EXEC: begin
        if (!stall) begin
          state_nxt = last_cell ? BK_IDLE : BK_READ;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
    end else if (state_r == BK_IDLE && job_valid) begin
      i_r <= job.ur_lo;
      j_r <= job.uc_lo;
    end else if (advance && !last_cell) begin
      if (j_r == job.uc_hi) begin
        j_r <= job.uc_lo;
        i_r <= i_r + 1'b1;
      end else begin
        j_r <= j_r + 1'b1;
      end
    end
  end

  // Running maxima; the read data is registered and valid in the cycle after the address settles.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[addr] <= newv;
    end
    rd_r <= store[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_strm.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r.pooled_value <= result;
      out_r.out_channel  <= job.channel;
      out_r.out_row      <= i_r;
      out_r.out_col      <= j_r;
      out_r.run_last     <= run_last;
      out_r.layer_done   <= run_last && job.layer_end;
    end
  end

  assign out_strm.valid = out_valid_r;
  assign out_strm.data  = out_r;

endmodule

[hdl/max_pool_2d_stream.sv]
// Top level of the streaming 2-D max pooling block with padding.
`timescale 1ns / 1ps
// Samples arrive in channel, row, column order, one per transfer; each result is
// the maximum of a pool_size square window at pool_stride, offset by -pad_amount,
// tagged with channel, output row and output column, and is emitted at the last
// in-range sample of its window (windows wholly past the edge give -32768).
// The front end accepts samples while its four-entry job queue has room. The back
// end, bound by the single port of the running-maximum memory, picks up a job in
// its idle state and then takes every window in the box spanned by the windows a
// sample touches or closes through a read state and an execute state, where a
// waiting result held by the output stalls it; a sample that touches no window
// queues no job. A write to any of the six registers restarts the stream at
// channel 0, row 0, column 0; after reset and after each such write the block
// computes the output sizes by repeated addition, with the input held off.
module max_pool_2d_stream (
  input  logic                                clk,
  input  logic                                rst_n,
  mp2d_stream_if.sink                         in_strm,
  mp2d_stream_if.source                       out_strm,
  input  logic                                cfg_we,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mp2d_pkg::*;

  logic [8:0]  in_width_r, in_height_r;
  logic [10:0] channel_count_r;
  logic [2:0]  pool_size_r, pool_stride_r;
  logic [1:0]  pad_amount_r;
  logic        start_r;
  logic [2:0]  k_m1;
  pool_cfg_t   cfg;
  logic        push, fifo_full, pop, head_valid;
  job_t        job_in, job_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r      <= 9'd1;
      in_height_r     <= 9'd1;
      channel_count_r <= 11'd1;
      pool_size_r     <= 3'd2;
      pool_stride_r   <= 3'd2;
      pad_amount_r    <= 2'd0;
      start_r         <= 1'b1;
    end else begin
      start_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_IN_WIDTH: begin
            in_width_r <= cfg_data[8:0];
            start_r    <= 1'b1;
          end
          REG_IN_HEIGHT: begin
            in_height_r <= cfg_data[8:0];
            start_r     <= 1'b1;
          end
          REG_CHANNEL_COUNT: begin
            channel_count_r <= cfg_data;
            start_r         <= 1'b1;
          end
          REG_POOL_SIZE: begin
            pool_size_r <= cfg_data[2:0];
            start_r     <= 1'b1;
          end
          REG_POOL_STRIDE: begin
            pool_stride_r <= cfg_data[2:0];
            start_r       <= 1'b1;
          end
          REG_PAD_AMOUNT: begin
            pad_amount_r <= cfg_data[1:0];
            start_r      <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Clamp the registers into their working ranges.
  always_comb begin
    cfg.w = (in_width_r == 9'd0) ? 9'd1 :
            (in_width_r > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : in_width_r;
    cfg.h = (in_height_r == 9'd0) ? 9'd1 :
            (in_height_r > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH) : in_height_r;
    cfg.nc = (channel_count_r == 11'd0) ? 11'd1 :
             (channel_count_r > 11'(MAX_CHANNELS)) ? 11'(MAX_CHANNELS) : channel_count_r;
    cfg.k = (pool_size_r == 3'd0) ? 3'd1 :
            (pool_size_r > 3'(MAX_POOL)) ? 3'(MAX_POOL) : pool_size_r;
    cfg.s = (pool_stride_r == 3'd0) ? 3'd1 : pool_stride_r;
    k_m1  = cfg.k - 3'd1;
    cfg.p = pad_amount_r;
    if ({1'b0, cfg.p} > k_m1) begin
      cfg.p = k_m1[1:0];
    end
    if (cfg.p > 2'(MAX_PAD)) begin
      cfg.p = 2'(MAX_PAD);
    end
  end

  mp2d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .cfg       (cfg),
    .in_strm   (in_strm),
    .fifo_full (fifo_full),
    .push      (push),
    .job       (job_in)
  );

  mp2d_job_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (job_in),
    .full      (fifo_full),
    .pop       (pop),
    .not_empty (head_valid),
    .dout      (job_head)
  );

  mp2d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (head_valid),
    .job       (job_head),
    .pop       (pop),
    .out_strm  (out_strm)
  );

endmodule

[bench/testbench.sv]
// Self-checking testbench for the streaming 2-D max pooling block.
`timescale 1ns / 1ps
module testbench;
  import mp2d_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_BEYOND_LIST = 3'd6;
  localparam int STORE_COLS = MAX_WIDTH + 2 * MAX_PAD;
  localparam int SETTLE_CYCLES = 400;

  // Tracks the layer configuration and running window maxima, and predicts results.
  class pool_scoreboard;
    int unsigned regs[6];
    int unsigned col_pos, row_pos, chan_pos;
    logic signed [DATA_W-1:0] win_max[MAX_POOL][STORE_COLS];
    out_item_t pending_results[$];
    int errors;

    function new();
      regs = '{1, 1, 1, 2, 2, 0};
      errors = 0;
      restart_stream();
    endfunction

    function void restart_stream();
      col_pos = 0;
      row_pos = 0;
      chan_pos = 0;
      foreach (win_max[a, b]) win_max[a][b] = MOST_NEG;
    endfunction

    function void write_reg(int unsigned idx, int unsigned value);
      int unsigned masks[6];
      masks = '{'h1FF, 'h1FF, 'h7FF, 'h7, 'h7, 'h3};
      if (idx >= 6) return;
      regs[idx] = value & masks[idx];
      restart_stream();
    endfunction

    static function int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // Output indices whose windows cover input position pos.
    static function bit cover_span(int pos, int k, int s, int p, int nout,
                                   output int lo, output int hi);
      int t;
      t = pos + p + 1;
      if (nout == 0) return 0;
      lo = (t <= k) ? 0 : (t - k + s - 1) / s;
      hi = (pos + p) / s;
      if (hi > nout - 1) hi = nout - 1;
      return lo <= hi;
    endfunction

    // Output indices whose windows close at input position pos.
    static function bit close_span(int pos, int dim, int k, int s, int p, int nout,
                                   output int lo, output int hi);
      int t;
      t = pos + p + 1;
      if (nout == 0) return 0;
      if (pos + 1 < dim) begin
        if (t < k) return 0;
        t -= k;
        if (t % s != 0) return 0;
        lo = t / s;
        hi = lo;
        return lo < nout;
      end
      lo = (t <= k) ? 0 : (t - k + s - 1) / s;
      hi = nout - 1;
      return lo <= hi;
    endfunction

    function void note_sample(logic signed [DATA_W-1:0] v);
      int w, h, nc, k, s, p, oh, ow, ra, rb, ca, cb, n;
      bit outside, last_px;
      out_item_t res;
      w = clamp(regs[0], 1, MAX_WIDTH);
      h = clamp(regs[1], 1, MAX_WIDTH);
      nc = clamp(regs[2], 1, MAX_CHANNELS);
      k = clamp(regs[3], 1, MAX_POOL);
      s = clamp(regs[4], 1, 7);
      p = clamp(regs[5], 0, k - 1);
      if (p > MAX_PAD) p = MAX_PAD;
      oh = (h + 2 * p) / s;
      ow = (w + 2 * p) / s;
      if (ow > STORE_COLS) ow = STORE_COLS;
      if (row_pos >= h || col_pos >= w || chan_pos >= nc) restart_stream();

      if (cover_span(row_pos, k, s, p, oh, ra, rb) && cover_span(col_pos, k, s, p, ow, ca, cb))
        for (int i = ra; i <= rb; i++)
          for (int j = ca; j <= cb; j++)
            if (v > win_max[i % MAX_POOL][j]) win_max[i % MAX_POOL][j] = v;

      last_px = (row_pos + 1 == h) && (col_pos + 1 == w);
      n = 0;
      if (close_span(row_pos, h, k, s, p, oh, ra, rb) &&
          close_span(col_pos, w, k, s, p, ow, ca, cb))
        for (int i = ra; i <= rb; i++)
          for (int j = ca; j <= cb; j++) begin
            outside = (i * s >= h + p) || (j * s >= w + p);
            res = '0;
            res.pooled_value = MOST_NEG;
            if (!outside) begin
              res.pooled_value = win_max[i % MAX_POOL][j];
              win_max[i % MAX_POOL][j] = MOST_NEG;
            end
            res.out_channel = chan_pos[CH_W-1:0];
            res.out_row = i[IDX_W-1:0];
            res.out_col = j[IDX_W-1:0];
            pending_results.push_back(res);
            n++;
          end
      if (n > 0) begin
        pending_results[$].run_last = 1'b1;
        pending_results[$].layer_done = last_px && (chan_pos + 1 == nc);
      end

      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) begin
          row_pos = 0;
          chan_pos++;
          if (chan_pos >= nc) chan_pos = 0;
        end
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_results.size() == 0) begin
        $error("result with none expected: value %0d ch %0d row %0d col %0d",
               got.pooled_value, got.out_channel, got.out_row, got.out_col);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.pooled_value !== exp_r.pooled_value) begin
        $error("pooled_value expected %0d actual %0d", exp_r.pooled_value, got.pooled_value);
        errors++;
      end
      if (got.out_channel !== exp_r.out_channel) begin
        $error("out_channel expected %0d actual %0d", exp_r.out_channel, got.out_channel);
        errors++;
      end
      if (got.out_row !== exp_r.out_row) begin
        $error("out_row expected %0d actual %0d", exp_r.out_row, got.out_row);
        errors++;
      end
      if (got.out_col !== exp_r.out_col) begin
        $error("out_col expected %0d actual %0d", exp_r.out_col, got.out_col);
        errors++;
      end
      if (got.run_last !== exp_r.run_last) begin
        $error("run_last expected %0d actual %0d", exp_r.run_last, got.run_last);
        errors++;
      end
      if (got.layer_done !== exp_r.layer_done) begin
        $error("layer_done expected %0d actual %0d", exp_r.layer_done, got.layer_done);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit steady;
  int random_items;
  pool_scoreboard sb;

  mp2d_stream_if #(.item_t(in_item_t)) in_if ();
  mp2d_stream_if #(.item_t(out_item_t)) out_if ();

  max_pool_2d_stream u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_strm  (in_if),
    .out_strm (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  // Holds the input off, waits until every predicted result has come, then lets
  // any queued work drain.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_layer(int unsigned w, int unsigned h, int unsigned nc,
                           int unsigned k, int unsigned s, int unsigned p);
    drain_results();
    write_cfg(REG_IN_WIDTH, w);
    write_cfg(REG_IN_HEIGHT, h);
    write_cfg(REG_CHANNEL_COUNT, nc);
    write_cfg(REG_POOL_SIZE, k);
    write_cfg(REG_POOL_STRIDE, s);
    write_cfg(REG_PAD_AMOUNT, p);
    steady = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_sample(logic signed [DATA_W-1:0] v);
    int gap;
    in_if.valid <= 1'b1;
    in_if.data.sample_value <= v;
    @(negedge clk);
    while (!in_if.ready) @(negedge clk);
    @(posedge clk);
    sb.note_sample(v);
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random(int count);
    repeat (count) send_sample($urandom());
  endtask

  // Result side: random stalls, then a transfer checked against the prediction.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(negedge clk);
      while (!out_if.valid) @(negedge clk);
      @(posedge clk);
      sb.check_result(out_if.data);
    end
  end

  initial begin
    int w, h, nc, frame, count;
    sb = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    steady = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset layout gives no output windows at all.
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);

    // Three by three map, full padding: seven by seven output windows, 25 of
    // them closed by the last sample.
    set_layer(3, 3, 1, 3, 1, 2);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sh0001);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    send_sample(16'sh8001);
    send_sample(16'sh7FFE);

    // Pad beyond pool_size-1 is saturated.
    set_layer(2, 2, 1, 2, 2, 3);
    repeat (4) send_sample($urandom());

    // Out-of-range register values, and a write past the register list.
    set_layer(0, 511, 2047, 0, 0, 3);
    write_cfg(REG_BEYOND_LIST, 'h7FF);
    repeat (6) send_sample($urandom());
    set_layer(3, 2, 1, 7, 7, 3);
    repeat (6) send_sample($urandom());

    // Extremes: widest row with the largest window, and many channels.
    set_layer(256, 1, 1, 4, 1, 3);
    send_random(256);
    set_layer(1, 1, 1024, 1, 1, 0);
    send_random(30);
    set_layer(5, 3, 2, 4, 4, 3);
    send_random(30);

    random_items = 0;
    while (random_items < 220) begin
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      nc = $urandom_range(1, 3);
      set_layer(w, h, nc, $urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 3));
      frame = w * h * nc;
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, frame + 3)
                                          : frame * $urandom_range(1, 2);
      send_random(count / 2);
      // In about one round in three, hold the input off until the block has delivered everything.
      if ($urandom_range(0, 2) == 0) begin
        in_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
      end
      send_random(count - count / 2);
      random_items += count;
    end

    in_if.valid <= 1'b0;
    drain_results();
    if (sb.errors == 0)
      $display("** max_pool_2d_stream: PASSED **");
    else
      $display("** max_pool_2d_stream: FAILED **");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("** max_pool_2d_stream: FAILED **");
    $finish;
  end

endmodule
